>>> hw/rtl/fdpda_pkg.sv
// fdpda_pkg: panel sizes, item codes and driver address tables for the
// flip-dot pixel difference addresser; no dependencies
package fdpda_pkg;

	localparam int PANEL_WIDTH  = 28;
	localparam int PANEL_HEIGHT = 9;
	localparam int MAP_DEPTH    = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int IDX_W        = $clog2(MAP_DEPTH);
	localparam int COL_W        = 5;
	localparam int ROW_W        = 4;
	localparam int ADDR_W       = 5;
	localparam int DRV_WORD_W   = 7;

	// digit and segment constants of the row driver address
	localparam logic [1:0] DIGIT_EDGE  = 2'b11;
	localparam logic [1:0] DIGIT_SET   = 2'd1;
	localparam logic [1:0] DIGIT_RESET = 2'd2;
	localparam logic [2:0] SEG_TOP_SET = 3'd1;
	localparam logic [2:0] SEG_TOP_RST = 3'd2;
	localparam logic [2:0] SEG_BOT_SET = 3'd5;
	localparam logic [2:0] SEG_BOT_RST = 3'd6;

	typedef enum logic {
		OP_DRAW = 1'b0,
		OP_FLAG = 1'b1
	} opcode_t;

	// map entry: bad-pixel flag over shown bit
	typedef struct packed {
		logic bad;
		logic shown;
	} map_entry_t;

	// column chip address for each panel column
	function automatic logic [ADDR_W-1:0] col_addr(input logic [COL_W-1:0] col);
		logic [ADDR_W-1:0] a;
		case (col)
			5'd0:  a = 5'd12;
			5'd1:  a = 5'd14;
			5'd2:  a = 5'd11;
			5'd3:  a = 5'd10;
			5'd4:  a = 5'd9;
			5'd5:  a = 5'd13;
			5'd6:  a = 5'd15;
			5'd7:  a = 5'd20;
			5'd8:  a = 5'd19;
			5'd9:  a = 5'd22;
			5'd10: a = 5'd18;
			5'd11: a = 5'd17;
			5'd12: a = 5'd21;
			5'd13: a = 5'd23;
			5'd14: a = 5'd31;
			5'd15: a = 5'd29;
			5'd16: a = 5'd30;
			5'd17: a = 5'd28;
			5'd18: a = 5'd27;
			5'd19: a = 5'd26;
			5'd20: a = 5'd25;
			5'd21: a = 5'd7;
			5'd22: a = 5'd5;
			5'd23: a = 5'd6;
			5'd24: a = 5'd4;
			5'd25: a = 5'd3;
			5'd26: a = 5'd2;
			5'd27: a = 5'd1;
			default: a = '0;
		endcase
		return a;
	endfunction

	// row chip address, which depends on the drive direction
	function automatic logic [ADDR_W-1:0] row_addr(input logic [ROW_W-1:0] row,
		input logic state);
		logic [ADDR_W-1:0] a;
		if (row == '0) begin
			a = {DIGIT_EDGE, state ? SEG_TOP_SET : SEG_TOP_RST};
		end else if (row == ROW_W'(PANEL_HEIGHT - 1)) begin
			a = {DIGIT_EDGE, state ? SEG_BOT_SET : SEG_BOT_RST};
		end else begin
			a = {state ? DIGIT_SET : DIGIT_RESET, 3'(ROW_W'(PANEL_HEIGHT - 1) - row)};
		end
		return a;
	endfunction

	// linear map index of a pixel inside the panel
	function automatic logic [IDX_W-1:0] pixel_index(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		return IDX_W'(IDX_W'(row) * IDX_W'(PANEL_WIDTH)) + IDX_W'(col);
	endfunction

endpackage

>>> hw/rtl/flipdot_pixel_diff_addresser.sv
// flipdot_pixel_diff_addresser: shown-screen and bad-pixel map memory with
// difference detection and driver word generation; uses fdpda_pkg

// Takes one word per cycle and, through stage 1 and the output register, raises
// out_valid when a draw changes a dot. Both maps share one 252 by 2-bit
// synchronous memory, read on acceptance and written back from stage 1;
// a write to the pixel being read is forwarded. A per-entry valid bit,
// cleared by reset, makes every entry read as zero until first written, so
// the block is ready straight out of reset with no clearing pass. Words
// outside the 28 by 9 panel are taken and dropped. The input stalls while a
// finished command waits at the output and a word sits in the pipeline,
// whether or not that word gives a command.
module flipdot_pixel_diff_addresser (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               opcode,
	input  logic [fdpda_pkg::COL_W-1:0]        col,
	input  logic [fdpda_pkg::ROW_W-1:0]        row,
	input  logic                               pixel_on,
	input  logic                               mask_on,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [fdpda_pkg::DRV_WORD_W-1:0]   column_word,
	output logic [fdpda_pkg::DRV_WORD_W-1:0]   row_word,
	output logic                               drive_state
);

	logic                             in_acc;
	logic                             in_panel;
	logic [fdpda_pkg::IDX_W-1:0]      rd_idx;

	logic                             valid_s1;
	logic                             in_panel_s1;
	logic [fdpda_pkg::IDX_W-1:0]      idx_s1;
	logic                             opcode_s1;
	logic [fdpda_pkg::COL_W-1:0]      col_s1;
	logic [fdpda_pkg::ROW_W-1:0]      row_s1;
	logic                             pixel_s1;
	logic                             mask_s1;
	logic                             ent_vld_s1;
	logic                             fwd_s1;
	fdpda_pkg::map_entry_t            fwd_data_s1;
	fdpda_pkg::map_entry_t            map_rd_s1;

	fdpda_pkg::map_entry_t            map_mem [fdpda_pkg::MAP_DEPTH];
	logic [fdpda_pkg::MAP_DEPTH-1:0]  ent_vld_q;

	fdpda_pkg::map_entry_t            cur_ent;
	fdpda_pkg::map_entry_t            wr_data;
	logic                             wr_en;
	logic                             s1_adv;
	logic                             target;
	logic                             drive;
	logic                             res_s1;

	logic                             out_valid_q;
	logic [fdpda_pkg::DRV_WORD_W-1:0] column_word_q;
	logic [fdpda_pkg::DRV_WORD_W-1:0] row_word_q;
	logic                             drive_state_q;

	// input decode
	assign in_panel = (col < fdpda_pkg::COL_W'(fdpda_pkg::PANEL_WIDTH)) &&
		(row < fdpda_pkg::ROW_W'(fdpda_pkg::PANEL_HEIGHT));
	assign rd_idx   = in_panel ? fdpda_pkg::pixel_index(row, col) : '0;
	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign in_acc   = in_valid && in_ready;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload, with forwarding of the write that lands on this edge
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_panel_s1 <= in_panel;
			idx_s1      <= rd_idx;
			opcode_s1   <= opcode;
			col_s1      <= col;
			row_s1      <= row;
			pixel_s1    <= pixel_on;
			mask_s1     <= mask_on;
			ent_vld_s1  <= ent_vld_q[rd_idx];
			fwd_s1      <= wr_en && (idx_s1 == rd_idx);
			fwd_data_s1 <= wr_data;
		end
	end

	// map memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[idx_s1] <= wr_data;
		end
		if (in_acc) begin
			map_rd_s1 <= map_mem[rd_idx];
		end
	end

	// entry valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wr_en) begin
			ent_vld_q[idx_s1] <= 1'b1;
		end
	end

	// modify: difference check and write-back data
	always_comb begin
		if (fwd_s1) begin
			cur_ent = fwd_data_s1;
		end else if (ent_vld_s1) begin
			cur_ent = map_rd_s1;
		end else begin
			cur_ent = '0;
		end
		target  = pixel_s1 && mask_s1;
		wr_data = cur_ent;
		if (opcode_s1 == fdpda_pkg::OP_FLAG) begin
			wr_data.bad = pixel_s1;
		end else begin
			wr_data.shown = target;
		end
		wr_en  = s1_adv && in_panel_s1;
		res_s1 = in_panel_s1 && (opcode_s1 == fdpda_pkg::OP_DRAW) &&
			(target != cur_ent.shown);
		drive  = target ^ cur_ent.bad;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && res_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && res_s1) begin
			column_word_q <= {~drive, 1'b0, fdpda_pkg::col_addr(col_s1)};
			row_word_q    <= {drive, 1'b0, fdpda_pkg::row_addr(row_s1, drive)};
			drive_state_q <= drive;
		end
	end

	assign out_valid   = out_valid_q;
	assign column_word = column_word_q;
	assign row_word    = row_word_q;
	assign drive_state = drive_state_q;

`ifndef SYNTHESIS
	// writes only ever target a pixel inside the panel
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (idx_s1 < fdpda_pkg::IDX_W'(fdpda_pkg::MAP_DEPTH)))
		else $error("map write outside the panel");

	// data bits of the two driver words are always opposite
	a_words_opposite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (column_word_q[6] != row_word_q[6]) &&
			(row_word_q[6] == drive_state_q))
		else $error("driver word data bits inconsistent");

	// a stalled stage 1 word keeps its pixel
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(idx_s1)))
		else $error("stage 1 word lost while stalled");

	// a taken command with no new one behind it empties the output
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && !(s1_adv && res_s1)) |=> !out_valid_q)
		else $error("output command repeated");
`endif

endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking bench for the flip-dot pixel difference addresser
// drives random and directed pixel words and checks each driver command
// depends on fdpda_pkg and flipdot_pixel_diff_addresser
`timescale 1ns / 100ps

typedef struct {
	logic [6:0] column_word;
	logic [6:0] row_word;
	logic       drive_state;
} drive_cmd_t;

// keeps its own copy of both panel maps and the commands still owed
class drive_cmd_board;
	localparam int NUM_DOTS = fdpda_pkg::PANEL_WIDTH * fdpda_pkg::PANEL_HEIGHT;
	localparam logic [4:0] COL_CHIP [28] = '{
		5'd12, 5'd14, 5'd11, 5'd10, 5'd9,  5'd13, 5'd15,
		5'd20, 5'd19, 5'd22, 5'd18, 5'd17, 5'd21, 5'd23,
		5'd31, 5'd29, 5'd30, 5'd28, 5'd27, 5'd26, 5'd25,
		5'd7,  5'd5,  5'd6,  5'd4,  5'd3,  5'd2,  5'd1
	};

	bit          shown_dots [NUM_DOTS];
	bit          bad_dots [NUM_DOTS];
	drive_cmd_t  owed_cmds [$];
	int unsigned faults;

	function new();
		foreach (shown_dots[i]) begin
			shown_dots[i] = 1'b0;
			bad_dots[i]   = 1'b0;
		end
		faults = 0;
	endfunction

	function void report(string msg);
		faults++;
		if (faults <= 10) begin
			$display("mismatch %0d: %s", faults, msg);
		end
	endfunction

	// row driver address, which flips digit or segment with the direction
	function logic [4:0] row_chip(logic [3:0] r, bit drive);
		logic [4:0] a;
		if (r == 4'd0) begin
			a = {2'b11, drive ? 3'd1 : 3'd2};
		end else if (r == 4'd8) begin
			a = {2'b11, drive ? 3'd5 : 3'd6};
		end else begin
			a = {drive ? 2'd1 : 2'd2, 3'(4'd8 - r)};
		end
		return a;
	endfunction

	// update the maps for one accepted word and queue any command it causes
	function void take_word(fdpda_pkg::opcode_t op, logic [4:0] c, logic [3:0] r,
		logic pix, logic msk);
		int idx;
		bit target;
		bit drive;
		drive_cmd_t cmd;
		if (c >= fdpda_pkg::PANEL_WIDTH || r >= fdpda_pkg::PANEL_HEIGHT) begin
			return;
		end
		idx = int'(r) * fdpda_pkg::PANEL_WIDTH + int'(c);
		if (op == fdpda_pkg::OP_FLAG) begin
			bad_dots[idx] = pix;
			return;
		end
		target = pix & msk;
		if (target == shown_dots[idx]) begin
			return;
		end
		shown_dots[idx] = target;
		drive = target ^ bad_dots[idx];
		cmd.column_word = {~drive, 1'b0, COL_CHIP[c]};
		cmd.row_word    = {drive, 1'b0, row_chip(r, drive)};
		cmd.drive_state = drive;
		owed_cmds.push_back(cmd);
	endfunction

	// compare one accepted command with the oldest one owed
	function void check_cmd(logic [6:0] cw, logic [6:0] rw, logic ds);
		drive_cmd_t exp_cmd;
		if (owed_cmds.size() == 0) begin
			report($sformatf("unexpected command col %h row %h drive %b", cw, rw, ds));
			return;
		end
		exp_cmd = owed_cmds.pop_front();
		if (cw !== exp_cmd.column_word || rw !== exp_cmd.row_word ||
			ds !== exp_cmd.drive_state) begin
			report($sformatf("expected col %h row %h drive %b, got col %h row %h drive %b",
				exp_cmd.column_word, exp_cmd.row_word, exp_cmd.drive_state, cw, rw, ds));
		end
	endfunction

	function int owed_count();
		return owed_cmds.size();
	endfunction
endclass

module tb_top;

	localparam int  RANDOM_WORDS = 1350;
	localparam int  HOLD_CYCLES  = 300;
	localparam int  DRAIN_CYCLES = 10;
	localparam time TIMEOUT_NS   = 800_000;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_ready;
	logic                             opcode;
	logic [fdpda_pkg::COL_W-1:0]      col;
	logic [fdpda_pkg::ROW_W-1:0]      row;
	logic                             pixel_on;
	logic                             mask_on;
	logic                             out_valid;
	logic                             out_ready;
	logic [fdpda_pkg::DRV_WORD_W-1:0] column_word;
	logic [fdpda_pkg::DRV_WORD_W-1:0] row_word;
	logic                             drive_state;

	bit             calm;
	bit             hold_off_req;
	drive_cmd_board board;

	flipdot_pixel_diff_addresser u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.col         (col),
		.row         (row),
		.pixel_on    (pixel_on),
		.mask_on     (mask_on),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.column_word (column_word),
		.row_word    (row_word),
		.drive_state (drive_state)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// about seven idle cycles in a hundred, none in a calm stretch
	function automatic bit idle_now();
		return !calm && ($urandom_range(0, 99) < 7);
	endfunction

	// offer one word from a falling edge and return at the falling edge after it is taken
	task automatic send_word(fdpda_pkg::opcode_t op, logic [fdpda_pkg::COL_W-1:0] c,
		logic [fdpda_pkg::ROW_W-1:0] r, logic pix, logic msk);
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		col      <= c;
		row      <= r;
		pixel_on <= pix;
		mask_on  <= msk;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly pixels inside the panel, some words anywhere in the field range
	task automatic send_random();
		logic [fdpda_pkg::COL_W-1:0] c;
		logic [fdpda_pkg::ROW_W-1:0] r;
		fdpda_pkg::opcode_t          op;
		if ($urandom_range(0, 99) < 15) begin
			c = fdpda_pkg::COL_W'($urandom);
			r = fdpda_pkg::ROW_W'($urandom);
		end else begin
			c = fdpda_pkg::COL_W'($urandom_range(0, fdpda_pkg::PANEL_WIDTH - 1));
			r = fdpda_pkg::ROW_W'($urandom_range(0, fdpda_pkg::PANEL_HEIGHT - 1));
		end
		op = ($urandom_range(0, 99) < 20) ? fdpda_pkg::OP_FLAG : fdpda_pkg::OP_DRAW;
		send_word(op, c, r, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// watch both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				board.take_word(fdpda_pkg::opcode_t'(opcode), col, row, pixel_on, mask_on);
			end
			if (out_valid && out_ready) begin
				board.check_cmd(column_word, row_word, drive_state);
			end
		end
	end

	// receiver: random back-pressure and one long hold-off on request
	initial begin
		int k;
		bit held;
		held      = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !held) begin
				held = 1'b1;
				for (k = 0; k < HOLD_CYCLES; k++) begin
					out_ready <= 1'b0;
					@(negedge clk);
				end
			end
			out_ready <= !idle_now();
		end
	end

	// overall limit on the run
	initial begin
		#(TIMEOUT_NS);
		$display("FAIL");
		$finish;
	end

	// reset, directed words, random words, drain
	initial begin
		int  n;
		board        = new();
		calm         = 1'b0;
		hold_off_req = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = fdpda_pkg::OP_DRAW;
		col          = '0;
		row          = '0;
		pixel_on     = 1'b0;
		mask_on      = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// set a dot, repeat it, then clear it through the mask
		send_word(fdpda_pkg::OP_DRAW, 5'd0, 4'd0, 1'b1, 1'b1);
		send_word(fdpda_pkg::OP_DRAW, 5'd0, 4'd0, 1'b1, 1'b1);
		send_word(fdpda_pkg::OP_DRAW, 5'd0, 4'd0, 1'b1, 1'b0);
		// target off on a dark dot gives nothing
		send_word(fdpda_pkg::OP_DRAW, 5'd5, 4'd3, 1'b0, 1'b1);
		send_word(fdpda_pkg::OP_DRAW, 5'd5, 4'd3, 1'b0, 1'b0);
		// bad dot at the far corner inverts the drive both ways
		send_word(fdpda_pkg::OP_FLAG, 5'd27, 4'd8, 1'b1, 1'b0);
		send_word(fdpda_pkg::OP_DRAW, 5'd27, 4'd8, 1'b1, 1'b1);
		send_word(fdpda_pkg::OP_DRAW, 5'd27, 4'd8, 1'b0, 1'b1);
		send_word(fdpda_pkg::OP_FLAG, 5'd27, 4'd8, 1'b0, 1'b1);
		send_word(fdpda_pkg::OP_DRAW, 5'd27, 4'd8, 1'b1, 1'b1);
		// words off the panel are dropped
		send_word(fdpda_pkg::OP_DRAW, 5'd28, 4'd0, 1'b1, 1'b1);
		send_word(fdpda_pkg::OP_DRAW, 5'd31, 4'd15, 1'b1, 1'b1);
		send_word(fdpda_pkg::OP_DRAW, 5'd0, 4'd9, 1'b1, 1'b1);
		send_word(fdpda_pkg::OP_FLAG, 5'd31, 4'd3, 1'b1, 1'b1);
		send_word(fdpda_pkg::OP_DRAW, 5'd31, 4'd3, 1'b1, 1'b1);
		// middle rows, set then reset
		for (n = 1; n < 8; n++) begin
			send_word(fdpda_pkg::OP_DRAW, 5'(n * 3), 4'(n), 1'b1, 1'b1);
		end
		send_word(fdpda_pkg::OP_DRAW, 5'd3, 4'd1, 1'b0, 1'b1);
		send_word(fdpda_pkg::OP_DRAW, 5'd21, 4'd7, 1'b1, 1'b0);

		n = 0;
		while (n < RANDOM_WORDS) begin
			if (n == 400) begin
				hold_off_req = 1'b1;
			end
			calm = (n >= 700 && n < 900);
			send_random();
			n++;
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (board.owed_count() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.faults == 0 && board.owed_count() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
